### src/cpt_pkg.sv
// Shared types and codes for the connection port table.
package cpt_pkg;

	// Command codes carried on the command port
	typedef enum logic [2:0] {
		CMD_LOOKUP   = 3'd0,
		CMD_DEMUX    = 3'd1,
		CMD_CONNECT  = 3'd2,
		CMD_ANNOUNCE = 3'd3,
		CMD_OPEN     = 3'd4,
		CMD_CLOSE    = 3'd5
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOMATCH = 2'd1,
		STAT_INUSE   = 2'd2,
		STAT_NOFREE  = 2'd3
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_NORMAL_BASE = 2'd0;
	localparam logic [1:0] CFG_PRIV_BASE   = 2'd1;
	localparam logic [1:0] CFG_PORT_LIMIT  = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ENTRY,
		S_ALLOC_CHK,
		S_ALLOC
	} state_t;

	// One table entry as stored in the entry RAM
	typedef struct packed {
		logic        in_use;
		logic [31:0] remote_addr;
		logic [15:0] remote_port;
		logic [15:0] local_port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Allocation window registers
	typedef struct packed {
		logic [15:0] normal_base;
		logic [15:0] priv_base;
		logic [15:0] limit;
	} cfg_t;

	// Entry RAM access strobes from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_en;
	} mem_ctl_t;

endpackage

### src/cpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, and read one word into the registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/cpt_ctrl.sv
// Command sequencer: entry scans, port allocation and read-modify-write of entries.
module cpt_ctrl #(
	parameter int ENTRIES = 16,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW = AW + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          command,
	input  logic [3:0]          entry,
	input  logic [15:0]         local_port,
	input  logic [15:0]         remote_port,
	input  logic [31:0]         remote_addr,
	input  logic                privileged,
	input  cpt_pkg::cfg_t       cfg,
	output cpt_pkg::mem_ctl_t   mem_ctl,
	output logic [AW-1:0]       rd_addr,
	output logic [AW-1:0]       wr_addr,
	output cpt_pkg::entry_t     wr_data,
	input  cpt_pkg::entry_t     rd_data,
	output logic                done,
	output logic                found,
	output logic [3:0]          match_index,
	output logic [15:0]         port,
	output logic [1:0]          status
);

	cpt_pkg::state_t  state_q, state_nxt;
	cpt_pkg::cmd_t    cmd_q;
	logic [3:0]       entry_q;
	logic [15:0]      lp_q;
	logic [15:0]      rp_q;
	logic [31:0]      ra_q;
	logic             priv_q;
	logic [15:0]      cand_q;
	logic             in_use_q;
	logic             taken_q;
	logic [CW-1:0]    cnt_q;
	logic             rd_s1;
	logic [AW-1:0]    idx_s1;
	logic             done_q;
	logic             found_q;
	logic [3:0]       idx_q;
	logic [15:0]      port_q;
	cpt_pkg::status_t status_q;

	logic             accept;
	logic             in_range;
	logic [AW-1:0]    entry_in_a;
	logic [AW-1:0]    entry_a;
	logic             scan_more;
	logic             last_s1;
	logic             lookup_hit;
	logic             demux_hit;
	logic [15:0]      key;
	logic             key_hit;
	logic             sel_hit;
	logic             scan_hit;
	logic             emit;
	logic             emit_found;
	logic [3:0]       emit_idx;
	logic [15:0]      emit_port;
	cpt_pkg::status_t emit_status;
	logic             cnt_clr;
	logic             scan_issue;
	logic             cand_ld;
	logic             cand_inc;
	logic             taken_ld;

	assign busy       = (state_q != cpt_pkg::S_IDLE);
	assign accept     = start && !busy;
	assign in_range   = (32'(entry) < 32'(ENTRIES));
	assign entry_in_a = AW'(entry);
	assign entry_a    = AW'(entry_q);
	assign scan_more  = (cnt_q < CW'(ENTRIES));
	assign last_s1    = rd_s1 && (idx_s1 == AW'(ENTRIES - 1));

	// Compare the entry read in the previous cycle
	assign lookup_hit = (rd_data.local_port == lp_q) && (rd_data.remote_port == rp_q) &&
		((rd_data.remote_addr == ra_q) || (ra_q == 32'd0));
	assign demux_hit  = rd_data.in_use && (rd_data.local_port == lp_q);
	assign key        = (state_q == cpt_pkg::S_ALLOC) ? cand_q : lp_q;
	assign key_hit    = (rd_data.local_port == key);

	always_comb begin
		case (cmd_q)
			cpt_pkg::CMD_LOOKUP: sel_hit = lookup_hit;
			cpt_pkg::CMD_DEMUX:  sel_hit = demux_hit;
			default:             sel_hit = key_hit;
		endcase
	end

	assign scan_hit = rd_s1 && ((state_q == cpt_pkg::S_ALLOC) ? key_hit : sel_hit);

	// Next state, RAM accesses and result
	always_comb begin
		state_nxt   = state_q;
		mem_ctl     = '0;
		rd_addr     = '0;
		wr_addr     = entry_a;
		wr_data     = '0;
		emit        = 1'b0;
		emit_found  = 1'b0;
		emit_idx    = '0;
		emit_port   = '0;
		emit_status = cpt_pkg::STAT_NOMATCH;
		cnt_clr     = 1'b0;
		scan_issue  = 1'b0;
		cand_ld     = 1'b0;
		cand_inc    = 1'b0;
		taken_ld    = 1'b0;
		unique case (state_q)
			cpt_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cpt_pkg::cmd_t'(command))
						cpt_pkg::CMD_LOOKUP, cpt_pkg::CMD_DEMUX: begin
							cnt_clr   = 1'b1;
							state_nxt = cpt_pkg::S_SCAN;
						end
						cpt_pkg::CMD_ANNOUNCE: begin
							if (in_range) begin
								cnt_clr   = 1'b1;
								state_nxt = cpt_pkg::S_SCAN;
							end else begin
								emit     = 1'b1;
								emit_idx = entry;
							end
						end
						cpt_pkg::CMD_CONNECT, cpt_pkg::CMD_OPEN: begin
							if (in_range) begin
								mem_ctl.rd_en = 1'b1;
								rd_addr       = entry_in_a;
								state_nxt     = cpt_pkg::S_ENTRY;
							end else begin
								emit     = 1'b1;
								emit_idx = entry;
							end
						end
						cpt_pkg::CMD_CLOSE: begin
							// drop the entry by clearing its valid bit
							emit     = 1'b1;
							emit_idx = entry;
							if (in_range) begin
								mem_ctl.clr_en = 1'b1;
								wr_addr        = entry_in_a;
								emit_found     = 1'b1;
								emit_status    = cpt_pkg::STAT_OK;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			cpt_pkg::S_SCAN: begin
				if (scan_hit) begin
					case (cmd_q)
						cpt_pkg::CMD_LOOKUP: begin
							emit        = 1'b1;
							emit_found  = 1'b1;
							emit_idx    = 4'(idx_s1);
							emit_port   = lp_q;
							emit_status = cpt_pkg::STAT_OK;
							state_nxt   = cpt_pkg::S_IDLE;
						end
						cpt_pkg::CMD_DEMUX: begin
							mem_ctl.wr_en       = 1'b1;
							wr_addr             = idx_s1;
							wr_data.in_use      = 1'b1;
							wr_data.remote_addr = ra_q;
							wr_data.remote_port = rp_q;
							wr_data.local_port  = rd_data.local_port;
							emit                = 1'b1;
							emit_found          = 1'b1;
							emit_idx            = 4'(idx_s1);
							emit_port           = lp_q;
							emit_status         = cpt_pkg::STAT_OK;
							state_nxt           = cpt_pkg::S_IDLE;
						end
						default: begin
							taken_ld      = 1'b1;
							mem_ctl.rd_en = 1'b1;
							rd_addr       = entry_a;
							state_nxt     = cpt_pkg::S_ENTRY;
						end
					endcase
				end else if (last_s1) begin
					if (cmd_q == cpt_pkg::CMD_ANNOUNCE) begin
						taken_ld      = 1'b1;
						mem_ctl.rd_en = 1'b1;
						rd_addr       = entry_a;
						state_nxt     = cpt_pkg::S_ENTRY;
					end else begin
						emit      = 1'b1;
						state_nxt = cpt_pkg::S_IDLE;
					end
				end else if (scan_more) begin
					scan_issue    = 1'b1;
					mem_ctl.rd_en = 1'b1;
					rd_addr       = cnt_q[AW-1:0];
				end
			end
			cpt_pkg::S_ENTRY: begin
				state_nxt = cpt_pkg::S_IDLE;
				emit_idx  = entry_q;
				case (cmd_q)
					cpt_pkg::CMD_CONNECT: begin
						if (rd_data.local_port != 16'd0) begin
							mem_ctl.wr_en       = 1'b1;
							wr_data.in_use      = rd_data.in_use;
							wr_data.remote_addr = ra_q;
							wr_data.remote_port = rp_q;
							wr_data.local_port  = rd_data.local_port;
							emit                = 1'b1;
							emit_found          = 1'b1;
							emit_port           = rd_data.local_port;
							emit_status         = cpt_pkg::STAT_OK;
						end else begin
							cand_ld   = 1'b1;
							state_nxt = cpt_pkg::S_ALLOC_CHK;
						end
					end
					cpt_pkg::CMD_ANNOUNCE: begin
						emit = 1'b1;
						if (taken_q) begin
							emit_port   = rd_data.local_port;
							emit_status = cpt_pkg::STAT_INUSE;
						end else begin
							mem_ctl.wr_en      = 1'b1;
							wr_data            = rd_data;
							wr_data.local_port = lp_q;
							emit_found         = 1'b1;
							emit_port          = lp_q;
							emit_status        = cpt_pkg::STAT_OK;
						end
					end
					default: begin
						// open
						mem_ctl.wr_en  = 1'b1;
						wr_data        = rd_data;
						wr_data.in_use = 1'b1;
						emit           = 1'b1;
						emit_found     = 1'b1;
						emit_port      = rd_data.local_port;
						emit_status    = cpt_pkg::STAT_OK;
					end
				endcase
			end
			cpt_pkg::S_ALLOC_CHK: begin
				if (cand_q >= cfg.limit) begin
					// no free port: still record the remote side
					mem_ctl.wr_en       = 1'b1;
					wr_data.in_use      = in_use_q;
					wr_data.remote_addr = ra_q;
					wr_data.remote_port = rp_q;
					emit                = 1'b1;
					emit_idx            = entry_q;
					emit_status         = cpt_pkg::STAT_NOFREE;
					state_nxt           = cpt_pkg::S_IDLE;
				end else begin
					cnt_clr   = 1'b1;
					state_nxt = cpt_pkg::S_ALLOC;
				end
			end
			cpt_pkg::S_ALLOC: begin
				if (scan_hit) begin
					cand_inc  = 1'b1;
					state_nxt = cpt_pkg::S_ALLOC_CHK;
				end else if (last_s1) begin
					mem_ctl.wr_en       = 1'b1;
					wr_data.in_use      = in_use_q;
					wr_data.remote_addr = ra_q;
					wr_data.remote_port = rp_q;
					wr_data.local_port  = cand_q;
					emit                = 1'b1;
					emit_found          = 1'b1;
					emit_idx            = entry_q;
					emit_port           = cand_q;
					emit_status         = cpt_pkg::STAT_OK;
					state_nxt           = cpt_pkg::S_IDLE;
				end else if (scan_more) begin
					scan_issue    = 1'b1;
					mem_ctl.rd_en = 1'b1;
					rd_addr       = cnt_q[AW-1:0];
				end
			end
			default: begin
				state_nxt = cpt_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpt_pkg::S_IDLE;
			cnt_q   <= '0;
			rd_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rd_s1   <= scan_issue;
			done_q  <= emit;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (scan_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Hold the command word, scan index, candidate port, entry flags and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cpt_pkg::cmd_t'(command);
			entry_q <= entry;
			lp_q    <= local_port;
			rp_q    <= remote_port;
			ra_q    <= remote_addr;
			priv_q  <= privileged;
		end
		idx_s1 <= cnt_q[AW-1:0];
		if (cand_ld) begin
			cand_q <= priv_q ? cfg.priv_base : cfg.normal_base;
		end else if (cand_inc) begin
			cand_q <= cand_q + 16'd1;
		end
		if (state_q == cpt_pkg::S_ENTRY) begin
			in_use_q <= rd_data.in_use;
		end
		if (taken_ld) begin
			taken_q <= scan_hit;
		end
		if (emit) begin
			found_q  <= emit_found;
			idx_q    <= emit_idx;
			port_q   <= emit_port;
			status_q <= emit_status;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign match_index = idx_q;
	assign port        = port_q;
	assign status      = status_q;

endmodule

### src/connection_port_table_core.sv
// Connection port table top level: config registers, entry valid bits, entry RAM, sequencer.
//
// One command is taken when start is high and busy is low; its result word appears on
// found, match_index, port and status for exactly one cycle with done high, and must be
// taken in that cycle. Close, unknown commands and out-of-range connect, announce and open
// finish without raising busy, with the result word registered in the cycle after the
// command is taken. Open and a connect to an entry that already has a local port read the
// entry, then write it back. Lookup and demux scan the table in order, one entry per cycle
// through the single read port of the entry RAM, stopping at the first match. Announce
// scans the table for its port, then reads the entry and writes the port unless it is
// taken. A connect that allocates a port rescans the table for every candidate port that
// is already taken, at most ENTRIES+1 candidates. The table is empty right after reset
// with no clearing pass: per-entry valid bits mark written entries.
module connection_port_table_core #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [3:0]  entry,
	input  logic [15:0] local_port,
	input  logic [15:0] remote_port,
	input  logic [31:0] remote_addr,
	input  logic        privileged,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        found,
	output logic [3:0]  match_index,
	output logic [15:0] port,
	output logic [1:0]  status
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	cpt_pkg::cfg_t                  cfg_q;
	logic [ENTRIES-1:0]             valid_q;
	logic                           rd_vld_s1;
	cpt_pkg::mem_ctl_t              mem_ctl;
	logic [AW-1:0]                  rd_addr;
	logic [AW-1:0]                  wr_addr;
	cpt_pkg::entry_t                wr_data;
	logic [cpt_pkg::ENTRY_W-1:0]    ram_rdata;
	cpt_pkg::entry_t                rd_data;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_base <= 16'd5000;
			cfg_q.priv_base   <= 16'd600;
			cfg_q.limit       <= 16'd65535;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cpt_pkg::CFG_NORMAL_BASE: cfg_q.normal_base <= cfg_data;
				cpt_pkg::CFG_PRIV_BASE:   cfg_q.priv_base   <= cfg_data;
				cpt_pkg::CFG_PORT_LIMIT:  cfg_q.limit       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Track written entries; an unwritten entry reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (mem_ctl.clr_en) begin
				valid_q[wr_addr] <= 1'b0;
			end
			if (mem_ctl.rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? cpt_pkg::entry_t'(ram_rdata) : '0;

	cpt_ram #(
		.WIDTH (cpt_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_ctl.wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (mem_ctl.rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	cpt_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.entry       (entry),
		.local_port  (local_port),
		.remote_port (remote_port),
		.remote_addr (remote_addr),
		.privileged  (privileged),
		.cfg         (cfg_q),
		.mem_ctl     (mem_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_data     (rd_data),
		.done        (done),
		.found       (found),
		.match_index (match_index),
		.port        (port),
		.status      (status)
	);

`ifndef SYNTH
	// Every command that ends its busy period delivers a result word
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result word");

	// A result word is only shown once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while busy");

	// Found and an ok status go together
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (found == (status == cpt_pkg::STAT_OK)))
		else $error("found and status disagree");

	// The RAM is never read and written in the same cycle
	a_no_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.wr_en || mem_ctl.clr_en) |-> !mem_ctl.rd_en)
		else $error("entry RAM read and write in the same cycle");
`endif

endmodule

### test/testbench.sv
// Testbench for the connection port table: random and directed commands checked against a table mirror.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES_N   = 16;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_WORDS = 158;

	// One command word as driven on the command ports
	typedef struct {
		logic [2:0]  cmd;
		logic [3:0]  ent;
		logic [15:0] lport;
		logic [15:0] rport;
		logic [31:0] raddr;
		logic        priv;
	} cmd_word_t;

	// One result word as seen on the result ports
	typedef struct {
		logic        found;
		logic [3:0]  idx;
		logic [15:0] port;
		logic [1:0]  status;
	} result_word_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [2:0]  command     = '0;
	logic [3:0]  entry       = '0;
	logic [15:0] local_port  = '0;
	logic [15:0] remote_port = '0;
	logic [31:0] remote_addr = '0;
	logic        privileged  = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic [1:0]  cfg_index   = '0;
	logic [15:0] cfg_data    = '0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic        found;
	logic [3:0]  match_index;
	logic [15:0] port;
	logic [1:0]  status;

	// Mirror of the table and of the allocation window
	logic [15:0] mirror_lport [ENTRIES_N] = '{default: '0};
	logic [15:0] mirror_rport [ENTRIES_N] = '{default: '0};
	logic [31:0] mirror_raddr [ENTRIES_N] = '{default: '0};
	logic        mirror_open  [ENTRIES_N] = '{default: 1'b0};
	logic [15:0] win_normal = 16'd5000;
	logic [15:0] win_priv   = 16'd600;
	logic [15:0] win_limit  = 16'hFFFF;

	cmd_word_t    cmd_backlog[$];
	result_word_t pending_results[$];
	int unsigned  words_queued    = 0;
	int unsigned  results_seen    = 0;
	int unsigned  fail_count      = 0;
	int unsigned  idle_cycles     = 0;
	int           sender_idle_pct = 6;

	connection_port_table_core #(.ENTRIES(ENTRIES_N)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.entry(entry),
		.local_port(local_port),
		.remote_port(remote_port),
		.remote_addr(remote_addr),
		.privileged(privileged),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.found(found),
		.match_index(match_index),
		.port(port),
		.status(status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// True when any entry holds the port as its local port, port zero included
	function automatic bit port_held(input logic [15:0] p);
		int i;
		for (i = 0; i < ENTRIES_N; i++)
			if (mirror_lport[i] == p)
				return 1'b1;
		return 1'b0;
	endfunction

	// Apply one command to the mirror and return the result word it yields
	function automatic result_word_t apply_command(input logic [2:0] op, input logic [3:0] e,
			input logic [15:0] lp, input logic [15:0] rp, input logic [31:0] ra,
			input logic priv);
		result_word_t r;
		logic [15:0]  base;
		int           i;
		int           p;
		bit           hit;
		r.found  = 1'b0;
		r.idx    = '0;
		r.port   = '0;
		r.status = cpt_pkg::STAT_NOMATCH;
		hit      = 1'b0;
		if (op == cpt_pkg::CMD_LOOKUP) begin
			// first entry matching both ports, address unless wildcard; in-use ignored
			for (i = 0; i < ENTRIES_N && !hit; i++)
				if (mirror_lport[i] == lp && mirror_rport[i] == rp &&
						(mirror_raddr[i] == ra || ra == '0)) begin
					hit      = 1'b1;
					r.found  = 1'b1;
					r.idx    = 4'(i);
					r.port   = mirror_lport[i];
					r.status = cpt_pkg::STAT_OK;
				end
		end else if (op == cpt_pkg::CMD_DEMUX) begin
			// first in-use entry bound to the port takes the sender
			for (i = 0; i < ENTRIES_N && !hit; i++)
				if (mirror_open[i] && mirror_lport[i] == lp) begin
					hit             = 1'b1;
					mirror_raddr[i] = ra;
					mirror_rport[i] = rp;
					r.found         = 1'b1;
					r.idx           = 4'(i);
					r.port          = mirror_lport[i];
					r.status        = cpt_pkg::STAT_OK;
				end
		end else if (op > cpt_pkg::CMD_CLOSE) begin
			// unknown command: no action, miss result
		end else if (int'(e) >= ENTRIES_N) begin
			r.idx = e;
		end else begin
			r.idx    = e;
			r.found  = 1'b1;
			r.status = cpt_pkg::STAT_OK;
			case (op)
				cpt_pkg::CMD_CONNECT: begin
					mirror_raddr[e] = ra;
					mirror_rport[e] = rp;
					// allocate the lowest free port of the window when unbound
					if (mirror_lport[e] == '0) begin
						base = priv ? win_priv : win_normal;
						for (p = int'(base); p < int'(win_limit) && !hit; p++)
							if (!port_held(16'(p))) begin
								hit             = 1'b1;
								mirror_lport[e] = 16'(p);
							end
						if (!hit) begin
							r.found  = 1'b0;
							r.status = cpt_pkg::STAT_NOFREE;
						end
					end
					r.port = mirror_lport[e];
				end
				cpt_pkg::CMD_ANNOUNCE: begin
					if (port_held(lp)) begin
						r.found  = 1'b0;
						r.status = cpt_pkg::STAT_INUSE;
						r.port   = mirror_lport[e];
					end else begin
						mirror_lport[e] = lp;
						r.port          = lp;
					end
				end
				cpt_pkg::CMD_OPEN: begin
					mirror_open[e] = 1'b1;
					r.port         = mirror_lport[e];
				end
				cpt_pkg::CMD_CLOSE: begin
					mirror_lport[e] = '0;
					mirror_rport[e] = '0;
					mirror_raddr[e] = '0;
					mirror_open[e]  = 1'b0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	function automatic cmd_word_t make_word(input logic [2:0] op, input logic [3:0] e,
			input logic [15:0] lp, input logic [15:0] rp, input logic [31:0] ra,
			input logic priv);
		cmd_word_t w;
		w.cmd   = op;
		w.ent   = e;
		w.lport = lp;
		w.rport = rp;
		w.raddr = ra;
		w.priv  = priv;
		return w;
	endfunction

	// Ports near the window bases collide often, as do 0, 1 and 0xFFFF; the rest spread over all bits
	function automatic logic [15:0] pool_port();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return win_normal + 16'($urandom_range(0, 3));
			2: return win_priv + 16'($urandom_range(0, 3));
			3: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] pool_addr();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0A00_0001;
			3: return 32'h0A00_0002;
			default: return $urandom();
		endcase
	endfunction

	// Random command word, biased toward the current table contents
	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int        k;
		int        pick;
		k       = $urandom_range(0, ENTRIES_N - 1);
		w.ent   = 4'($urandom_range(0, 15));
		w.lport = pool_port();
		w.rport = ($urandom_range(0, 1) != 0) ? pool_port() : 16'($urandom_range(1, 3));
		w.raddr = pool_addr();
		w.priv  = 1'($urandom_range(0, 1));
		pick    = $urandom_range(0, 99);
		if (pick < 20) begin
			w.cmd = cpt_pkg::CMD_CONNECT;
		end else if (pick < 30) begin
			w.cmd = cpt_pkg::CMD_ANNOUNCE;
			if ($urandom_range(0, 3) == 0)
				w.lport = mirror_lport[k];
		end else if (pick < 42) begin
			w.cmd = cpt_pkg::CMD_OPEN;
		end else if (pick < 53) begin
			w.cmd = cpt_pkg::CMD_CLOSE;
		end else if (pick < 74) begin
			w.cmd = cpt_pkg::CMD_LOOKUP;
			if ($urandom_range(0, 4) < 3) begin
				w.lport = mirror_lport[k];
				w.rport = mirror_rport[k];
				w.raddr = ($urandom_range(0, 2) == 0) ? 32'd0 : mirror_raddr[k];
			end
		end else if (pick < 95) begin
			w.cmd = cpt_pkg::CMD_DEMUX;
			if ($urandom_range(0, 4) < 3)
				w.lport = mirror_lport[k];
		end else begin
			w.cmd = 3'($urandom_range(6, 7));
		end
		return w;
	endfunction

	task automatic queue_word(input cmd_word_t w);
		cmd_backlog.push_back(w);
		words_queued++;
	endtask

	// Hold until every queued word has its result, then let the block settle
	task automatic wait_results();
		while (results_seen < words_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three window registers back to back; call only while idle
	task automatic program_window(input logic [15:0] nb, input logic [15:0] pb,
			input logic [15:0] lim);
		logic [1:0]  idx [3];
		logic [15:0] val [3];
		int          k;
		idx = '{cpt_pkg::CFG_NORMAL_BASE, cpt_pkg::CFG_PRIV_BASE, cpt_pkg::CFG_PORT_LIMIT};
		val = '{nb, pb, lim};
		for (k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid  <= 1'b0;
		win_normal = nb;
		win_priv   = pb;
		win_limit  = lim;
	endtask

	// Stimulus: directed words, then random phases over several windows
	initial begin
		int ph;
		int n;
		int g;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_window(16'd5000, 16'd600, 16'hFFFF);

		// cleared table: all-zero lookup hits entry 0, others miss
		queue_word(make_word(cpt_pkg::CMD_LOOKUP, 4'd0, 16'd0, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_LOOKUP, 4'd0, 16'hFFFF, 16'hFFFF,
				32'hFFFF_FFFF, 1'b1));
		queue_word(make_word(cpt_pkg::CMD_DEMUX, 4'd0, 16'd0, 16'd7, 32'h1, 1'b0));
		// allocation from both bases, then connect to a bound entry
		queue_word(make_word(cpt_pkg::CMD_CONNECT, 4'd0, 16'd0, 16'd80, 32'h0A00_0001, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_CONNECT, 4'd1, 16'd0, 16'd443, 32'h0A00_0002, 1'b1));
		queue_word(make_word(cpt_pkg::CMD_CONNECT, 4'd0, 16'd0, 16'd81, 32'h0A00_0003, 1'b0));
		// announce: taken port, port zero, top port and a free port, then allocation skips taken ports
		queue_word(make_word(cpt_pkg::CMD_ANNOUNCE, 4'd2, 16'd5000, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_ANNOUNCE, 4'd2, 16'd0, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_ANNOUNCE, 4'd2, 16'hFFFF, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_ANNOUNCE, 4'd3, 16'd5001, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_CONNECT, 4'd4, 16'd0, 16'hFFFF,
				32'hFFFF_FFFF, 1'b0));
		// open, demux into it, lookup by wildcard and by a wrong address
		queue_word(make_word(cpt_pkg::CMD_OPEN, 4'd0, 16'd0, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_DEMUX, 4'd0, 16'd5000, 16'd1234,
				32'hC0A8_0001, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_LOOKUP, 4'd0, 16'd5000, 16'd1234, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_LOOKUP, 4'd0, 16'd5000, 16'd1234,
				32'hC0A8_0002, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_CLOSE, 4'd0, 16'd0, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_LOOKUP, 4'd0, 16'd0, 16'd0, 32'd0, 1'b0));
		// unknown commands, highest entry
		queue_word(make_word(3'd6, 4'd0, 16'd0, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(3'd7, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
		queue_word(make_word(cpt_pkg::CMD_OPEN, 4'hF, 16'd0, 16'd0, 32'd0, 1'b0));
		queue_word(make_word(cpt_pkg::CMD_CLOSE, 4'hF, 16'd0, 16'd0, 32'd0, 1'b0));
		wait_results();

		// privileged base at the limit: no free port; normal base at the bottom
		program_window(16'd1, 16'hFFFF, 16'hFFFF);
		queue_word(make_word(cpt_pkg::CMD_CONNECT, 4'd5, 16'd0, 16'd9, 32'h0A00_0009, 1'b1));
		queue_word(make_word(cpt_pkg::CMD_CONNECT, 4'd6, 16'd0, 16'd9, 32'h0A00_0009, 1'b0));
		wait_results();
		program_window(16'd600, 16'd600, 16'd1);
		queue_word(make_word(cpt_pkg::CMD_CONNECT, 4'd7, 16'd0, 16'd10, 32'h0A00_000A, 1'b0));

		for (ph = 0; ph < 6; ph++) begin
			wait_results();
			case (ph)
				0: program_window(16'd5000, 16'd600, 16'hFFFF);
				1: program_window(16'd1, 16'hFFFE, 16'hFFFF);
				2: program_window(16'hFFFF, 16'd1, 16'hFFFF);
				5: program_window(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
						16'($urandom_range(1, 65535)));
				default: program_window(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
						16'($urandom_range(1, 60)));
			endcase
			for (n = 0; n < PHASE_WORDS; n++) begin
				g = ph * PHASE_WORDS + n;
				sender_idle_pct = (g < 2 * PHASE_WORDS) ? 6 : (g < 4 * PHASE_WORDS) ? 74 : 0;
				while (cmd_backlog.size() > 1)
					@(posedge clk);
				queue_word(random_word());
				// now and then let the table drain completely
				if ($urandom_range(0, 59) == 0)
					wait_results();
			end
		end

		wait_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Drive command words; hold a word until busy drops, predict at acceptance
	always @(posedge clk) begin
		cmd_word_t w;
		if (arst_n) begin
			if (start && !busy)
				pending_results.push_back(apply_command(command, entry, local_port,
						remote_port, remote_addr, privileged));
			if (!(start && busy)) begin
				if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					w = cmd_backlog.pop_front();
					start       <= 1'b1;
					command     <= w.cmd;
					entry       <= w.ent;
					local_port  <= w.lport;
					remote_port <= w.rport;
					remote_addr <= w.raddr;
					privileged  <= w.priv;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Compare each result word against the oldest prediction
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with none expected, actual found=%0b idx=%0d port=%0h status=%0d",
						$time, found, match_index, port, status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("found", 32'(want.found), 32'(found));
				check_field("match_index", 32'(want.idx), 32'(match_index));
				check_field("port", 32'(want.port), 32'(port));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
	end

	// Drop the run when no word moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule
